>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// A condition that implies another in the same cycle.
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// A condition that implies another in the following cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/aih_pkg.sv
// Shared types and constants of the arrival interval histogram.
package aih_pkg;

    localparam int TS_SEC_W    = 32;
    localparam int TS_NSEC_W   = 30;
    localparam int INTERVAL_W  = 63;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int BIN_INDEX_W = 7;
    localparam int BIN_COUNT_W = 32;

    localparam logic [TS_NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NS = 1'd1;

    localparam logic [CFG_W-1:0] MIN_RESET_NS = 32'd500000;
    localparam logic [CFG_W-1:0] MAX_RESET_NS = 32'd7000000;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic valid;
        logic incr;
    } t_hist_req;

    typedef struct packed {
        logic ready;
        logic resp_valid;
    } t_hist_status;

endpackage

>>> hw/rtl/aih_interval.sv
// Bit-serial interval unit: absolute difference of two timestamps in nanoseconds.
`include "assert_macros.svh"

module aih_interval (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [aih_pkg::TS_SEC_W-1:0]    i_sec,
    input  logic [aih_pkg::TS_NSEC_W-1:0]   i_nsec,
    input  logic [aih_pkg::TS_SEC_W-1:0]    i_prev_sec,
    input  logic [aih_pkg::TS_NSEC_W-1:0]   i_prev_nsec,
    output logic                            o_done,
    output logic [aih_pkg::INTERVAL_W-1:0]  o_interval
);

    localparam int SW = aih_pkg::TS_SEC_W;
    localparam int NW = aih_pkg::TS_NSEC_W;
    localparam int IW = aih_pkg::INTERVAL_W;
    localparam int CW = $clog2(SW);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL  = 4'b0010,
        P_SUM  = 4'b0100,
        P_ABS  = 4'b1000
    } t_ivl_phase;

    t_ivl_phase     r_phase;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [SW-1:0]  r_mul;
    logic [NW-1:0]  r_acc;
    logic [SW-1:0]  r_lo;
    logic [NW:0]    r_dn;
    logic           r_neg;
    logic [IW:0]    r_d;

    logic [SW:0]    dsec;
    logic [SW-1:0]  mag_sec;
    logic [NW:0]    psum;
    logic [IW:0]    prod;
    logic [IW:0]    dn_ext;
    logic [IW:0]    dsum;
    logic [IW:0]    dabs;

    always_comb begin
        dsec    = {1'b0, i_sec} - {1'b0, i_prev_sec};
        mag_sec = dsec[SW] ? SW'(-dsec) : dsec[SW-1:0];
        // One seconds bit per cycle: add the constant, shift one product bit out.
        psum    = {1'b0, r_acc} + (r_mul[0] ? {1'b0, aih_pkg::NS_PER_SEC} : '0);
        prod    = (IW+1)'({r_acc, r_lo});
        dn_ext  = {{(IW-NW){r_dn[NW]}}, r_dn};
        dsum    = r_neg ? (dn_ext - prod) : (dn_ext + prod);
        dabs    = r_d[IW] ? -r_d : r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_MUL;
                        r_cnt   <= '0;
                    end
                end
                P_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SW - 1)) begin
                        r_phase <= P_SUM;
                    end
                end
                P_SUM: begin
                    r_phase <= P_ABS;
                end
                P_ABS: begin
                    r_phase <= P_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul <= mag_sec;
            r_neg <= dsec[SW];
            r_dn  <= {1'b0, i_nsec} - {1'b0, i_prev_nsec};
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_phase == P_MUL) begin
            r_acc <= psum[NW:1];
            r_lo  <= {psum[0], r_lo[SW-1:1]};
            r_mul <= r_mul >> 1;
        end
        if (r_phase == P_SUM) begin
            r_d <= dsum;
        end
        if (r_phase == P_ABS) begin
            r_d <= dabs;
        end
    end

    assign o_done     = r_done;
    assign o_interval = r_d[IW-1:0];

    `AST_IMPLIES(a_start_when_idle, i_clk, i_rst_n, i_start, r_phase == P_IDLE)

endmodule

>>> hw/rtl/aih_bin_div.sv
// Bin selection: scales the interval into a bin with a bit-serial restoring divider.
`include "assert_macros.svh"

module aih_bin_div #(
    parameter int BINS = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [aih_pkg::INTERVAL_W-1:0]  i_interval,
    input  logic [aih_pkg::CFG_W-1:0]       i_min,
    input  logic [aih_pkg::CFG_W-1:0]       i_max,
    output logic                            o_done,
    output logic [$clog2(BINS)-1:0]         o_bin
);

    localparam int IW = aih_pkg::INTERVAL_W;
    localparam int VW = aih_pkg::CFG_W;
    localparam int QW = $clog2(BINS);
    localparam int BW = $clog2(BINS + 1);
    localparam int PW = VW + BW;
    localparam int KW = $clog2(QW + 1);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_PREP  = 4'b0010,
        D_SCALE = 4'b0100,
        D_DIV   = 4'b1000
    } t_div_phase;

    t_div_phase     r_phase;
    logic [KW-1:0]  r_cnt;
    logic           r_done;
    logic [IW-1:0]  r_ivl;
    logic [IW-1:0]  r_off;
    logic [VW-1:0]  r_span;
    logic           r_zero;
    logic           r_full;
    logic [VW-1:0]  r_rem;
    logic [QW-1:0]  r_q;
    logic [QW-1:0]  r_bin;

    logic [IW-1:0]  min_ext;
    logic [IW-1:0]  span_ext;
    logic [PW-1:0]  prod;
    logic [VW:0]    trial;
    logic           ge;
    logic [VW-1:0]  rem_n;
    logic [QW-1:0]  q_n;

    always_comb begin
        min_ext  = {{(IW-VW){1'b0}}, i_min};
        span_ext = {{(IW-VW){1'b0}}, r_span};
        prod     = PW'(r_off[VW-1:0]) * PW'(BINS);
        // The offset is below the span, so the quotient fits in QW bits and the
        // upper part of the scaled offset is already a valid partial remainder.
        trial    = {r_rem, r_q[QW-1]};
        ge       = trial >= {1'b0, r_span};
        rem_n    = ge ? VW'(trial - {1'b0, r_span}) : trial[VW-1:0];
        q_n      = QW'({r_q, ge});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                D_IDLE: begin
                    if (i_start) begin
                        r_phase <= D_PREP;
                    end
                end
                D_PREP: begin
                    r_phase <= D_SCALE;
                end
                D_SCALE: begin
                    r_phase <= D_DIV;
                    r_cnt   <= KW'(QW);
                end
                D_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == KW'(1)) begin
                        r_phase <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ivl <= i_interval;
        end
        if (r_phase == D_PREP) begin
            r_zero <= (i_max <= i_min) || (r_ivl <= min_ext);
            r_off  <= r_ivl - min_ext;
            r_span <= i_max - i_min;
        end
        if (r_phase == D_SCALE) begin
            r_full <= r_off >= span_ext;
            r_rem  <= prod[QW+VW-1:QW];
            r_q    <= prod[QW-1:0];
        end
        if (r_phase == D_DIV) begin
            r_rem <= rem_n;
            r_q   <= q_n;
            if (r_cnt == KW'(1)) begin
                r_bin <= r_zero ? '0 : (r_full ? QW'(BINS - 1) : q_n);
            end
        end
    end

    assign o_done = r_done;
    assign o_bin  = r_bin;

    `AST_IMPLIES(a_bin_in_range, i_clk, i_rst_n, r_done, 32'(r_bin) < 32'(BINS))

endmodule

>>> hw/rtl/aih_hist.sv
// Histogram store: bin counters in a memory with a clearing sweep and a saturating update.
`include "assert_macros.svh"

module aih_hist #(
    parameter int BINS        = 128,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aih_pkg::t_hist_req          i_req,
    input  logic [$clog2(BINS)-1:0]     i_addr,
    output aih_pkg::t_hist_status       o_status,
    output logic [COUNT_WIDTH-1:0]      o_count
);

    localparam int AW = $clog2(BINS);

    logic [COUNT_WIDTH-1:0] r_mem [BINS];
    logic [COUNT_WIDTH-1:0] r_rd;
    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_s1_valid;
    logic                   r_s1_incr;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_resp_valid;
    logic                   r_resp_incr;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] inc_count;

    always_comb begin
        inc_count = (&r_rd) ? r_rd : (r_rd + 1'b1);
        wr_en     = r_clr_busy || (r_s1_valid && r_s1_incr);
        wr_addr   = r_clr_busy ? r_clr_addr : r_s1_addr;
        wr_data   = r_clr_busy ? '0 : inc_count;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.valid) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_resp_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(BINS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid   <= i_req.valid;
            r_resp_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_s1_incr <= i_req.incr;
            r_s1_addr <= i_addr;
        end
        if (r_s1_valid) begin
            r_resp_incr <= r_s1_incr;
            r_count     <= r_s1_incr ? inc_count : r_rd;
        end
    end

    assign o_status.ready      = !r_clr_busy;
    assign o_status.resp_valid = r_resp_valid;
    assign o_count             = r_count;

    `AST_IMPLIES(a_no_req_in_clear, i_clk, i_rst_n, i_req.valid, !r_clr_busy)
    `AST_IMPLIES(a_incr_nonzero, i_clk, i_rst_n, r_resp_valid && r_resp_incr, r_count != '0)

endmodule

>>> hw/rtl/arrival_interval_histogram.sv
// Top level of the arrival interval histogram: control, configuration and result register.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_op, i_arrival_sec, i_arrival_nsec, i_read_bin
//   result    out        o_valid / i_stall   o_bin_index, o_bin_count, o_counted
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A counted arrival passes through the seconds-by-constant serial multiplier and then the
// serial divider, which forms ceil(log2(BINS)) quotient bits. After reset the counter
// memory is swept clear with o_stall high. A stalled result waits in the output register
// while the next item is already taken.
`include "assert_macros.svh"

module arrival_interval_histogram #(
    parameter int BINS        = 128,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aih_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aih_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic [aih_pkg::TS_SEC_W-1:0]      i_arrival_sec,
    input  logic [aih_pkg::TS_NSEC_W-1:0]     i_arrival_nsec,
    input  logic [aih_pkg::BIN_INDEX_W-1:0]   i_read_bin,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [aih_pkg::BIN_INDEX_W-1:0]   o_bin_index,
    output logic [aih_pkg::BIN_COUNT_W-1:0]   o_bin_count,
    output logic                              o_counted
);

    localparam int AW  = $clog2(BINS);
    localparam int OIW = aih_pkg::BIN_INDEX_W;
    localparam int OCW = aih_pkg::BIN_COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TIME = 5'b00010,
        S_BIN  = 5'b00100,
        S_MEM  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                             r_state;
    t_state                             n_state;
    logic [aih_pkg::CFG_W-1:0]          r_min;
    logic [aih_pkg::CFG_W-1:0]          r_max;
    logic [aih_pkg::TS_SEC_W-1:0]       r_prev_sec;
    logic [aih_pkg::TS_NSEC_W-1:0]      r_prev_nsec;
    logic                               r_have_prev;
    logic [OIW-1:0]                     r_res_index;
    logic [COUNT_WIDTH-1:0]             r_res_count;
    logic                               r_res_counted;
    logic                               r_out_valid;
    logic [OIW-1:0]                     r_out_index;
    logic [OCW-1:0]                     r_out_count;
    logic                               r_out_counted;

    logic                               in_acc;
    logic                               out_load;
    logic                               rd_in_range;
    logic                               read_go;
    logic                               ivl_start;
    logic                               ivl_done;
    logic [aih_pkg::INTERVAL_W-1:0]     ivl_value;
    logic                               div_start;
    logic                               div_done;
    logic                               div_go;
    logic [AW-1:0]                      div_bin;
    aih_pkg::t_hist_req                 hist_req;
    aih_pkg::t_hist_status              hist_stat;
    logic [AW-1:0]                      hist_addr;
    logic [COUNT_WIDTH-1:0]             hist_count;

    always_comb begin
        o_stall     = !((r_state == S_IDLE) && hist_stat.ready);
        in_acc      = i_valid && !o_stall;
        out_load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);
        rd_in_range = 32'(i_read_bin) < 32'(BINS);
        read_go     = in_acc && (i_op == aih_pkg::OP_READ) && rd_in_range;
        ivl_start   = in_acc && (i_op == aih_pkg::OP_RECORD) && r_have_prev;
        div_start   = (r_state == S_TIME) && ivl_done;
        div_go      = (r_state == S_BIN) && div_done;
        hist_req.valid = read_go || div_go;
        hist_req.incr  = div_go;
        hist_addr      = div_go ? div_bin : AW'(i_read_bin);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op == aih_pkg::OP_READ) begin
                        n_state = rd_in_range ? S_MEM : S_DONE;
                    end else if (!r_have_prev) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_TIME;
                    end
                end
            end
            S_TIME: begin
                if (ivl_done) begin
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                if (div_done) begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                if (hist_stat.resp_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= aih_pkg::MIN_RESET_NS;
            r_max       <= aih_pkg::MAX_RESET_NS;
            r_prev_sec  <= '0;
            r_prev_nsec <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aih_pkg::CFG_MIN_NS: r_min <= i_cfg_data;
                    aih_pkg::CFG_MAX_NS: r_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // Every recorded arrival becomes the reference for the next interval.
            if (in_acc && (i_op == aih_pkg::OP_RECORD)) begin
                r_prev_sec  <= i_arrival_sec;
                r_prev_nsec <= i_arrival_nsec;
                r_have_prev <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_index   <= (i_op == aih_pkg::OP_READ) ? i_read_bin : '0;
            r_res_count   <= '0;
            r_res_counted <= (i_op == aih_pkg::OP_RECORD) && r_have_prev;
        end
        if (div_go) begin
            r_res_index <= OIW'(div_bin);
        end
        if ((r_state == S_MEM) && hist_stat.resp_valid) begin
            r_res_count <= hist_count;
        end
        if (out_load) begin
            r_out_index   <= r_res_index;
            r_out_count   <= OCW'(r_res_count);
            r_out_counted <= r_res_counted;
        end
    end

    aih_interval u_interval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (ivl_start),
        .i_sec       (i_arrival_sec),
        .i_nsec      (i_arrival_nsec),
        .i_prev_sec  (r_prev_sec),
        .i_prev_nsec (r_prev_nsec),
        .o_done      (ivl_done),
        .o_interval  (ivl_value)
    );

    aih_bin_div #(
        .BINS (BINS)
    ) u_bin_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_interval (ivl_value),
        .i_min      (r_min),
        .i_max      (r_max),
        .o_done     (div_done),
        .o_bin      (div_bin)
    );

    aih_hist #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (hist_req),
        .i_addr   (hist_addr),
        .o_status (hist_stat),
        .o_count  (hist_count)
    );

    assign o_valid     = r_out_valid;
    assign o_bin_index = r_out_index;
    assign o_bin_count = r_out_count;
    assign o_counted   = r_out_counted;

    `AST_NEXT(a_done_fills_output, i_clk, i_rst_n, (r_state == S_DONE) && !r_out_valid, r_out_valid && (r_state == S_IDLE))

endmodule

>>> verif/arrival_interval_histogram_checker.sv
// Checker for the arrival interval histogram: predicts each result and compares it.
module arrival_interval_histogram_checker #(
    parameter int BINS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aih_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aih_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_op,
    input  logic [aih_pkg::TS_SEC_W-1:0]      i_arrival_sec,
    input  logic [aih_pkg::TS_NSEC_W-1:0]     i_arrival_nsec,
    input  logic [aih_pkg::BIN_INDEX_W-1:0]   i_read_bin,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [aih_pkg::BIN_INDEX_W-1:0]   i_bin_index,
    input  logic [aih_pkg::BIN_COUNT_W-1:0]   i_bin_count,
    input  logic                              i_counted,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import aih_pkg::*;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [BIN_COUNT_W-1:0] bin_count;
        logic                   counted;
    } t_bin_result;

    logic [CFG_W-1:0]       lower_ns;
    logic [CFG_W-1:0]       upper_ns;
    logic [TS_SEC_W-1:0]    last_sec;
    logic [TS_NSEC_W-1:0]   last_nsec;
    logic                   seen_arrival;
    logic [BIN_COUNT_W-1:0] hist [BINS];
    t_bin_result            expected_bins [$];
    int                     fail_total = 0;
    int                     checked_total = 0;

    // Maps an interval onto the configured range with exact integer division.
    function automatic int unsigned bin_for_interval(input logic [63:0] gap);
        logic [63:0] span;
        logic [63:0] offset;
        if (upper_ns <= lower_ns || gap <= 64'(lower_ns))
            return 0;
        span   = 64'(upper_ns) - 64'(lower_ns);
        offset = gap - 64'(lower_ns);
        if (offset >= span)
            return BINS - 1;
        offset = (offset * 64'(BINS)) / span;
        if (offset >= 64'(BINS))
            return BINS - 1;
        return int'(offset);
    endfunction

    always @(posedge i_clk) begin : watch
        t_bin_result got;
        t_bin_result want;
        logic [63:0] now_ns;
        logic [63:0] prev_ns;
        int unsigned slot;
        if (!i_rst_n) begin
            lower_ns     = MIN_RESET_NS;
            upper_ns     = MAX_RESET_NS;
            last_sec     = '0;
            last_nsec    = '0;
            seen_arrival = 1'b0;
            foreach (hist[k])
                hist[k] = '0;
            expected_bins.delete();
        end else begin
            // The result side is checked first: a result can never belong to an item
            // taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                got = '{i_bin_index, i_bin_count, i_counted};
                checked_total++;
                if (expected_bins.size() == 0) begin
                    $error("result transfer with nothing expected: bin_index %0d bin_count %0d",
                           got.bin_index, got.bin_count);
                    fail_total++;
                end else begin
                    want = expected_bins.pop_front();
                    if (got.bin_index !== want.bin_index) begin
                        $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
                        fail_total++;
                    end
                    if (got.bin_count !== want.bin_count) begin
                        $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
                        fail_total++;
                    end
                    if (got.counted !== want.counted) begin
                        $error("counted: expected %0d, got %0d", want.counted, got.counted);
                        fail_total++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_NS: lower_ns = i_cfg_data;
                    CFG_MAX_NS: upper_ns = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                want = '0;
                if (i_op == OP_READ) begin
                    want.bin_index = i_read_bin;
                    if (int'(i_read_bin) < BINS)
                        want.bin_count = hist[i_read_bin];
                end else if (!seen_arrival) begin
                    last_sec     = i_arrival_sec;
                    last_nsec    = i_arrival_nsec;
                    seen_arrival = 1'b1;
                end else begin
                    now_ns  = 64'(i_arrival_sec) * 64'(NS_PER_SEC) + 64'(i_arrival_nsec);
                    prev_ns = 64'(last_sec) * 64'(NS_PER_SEC) + 64'(last_nsec);
                    slot    = bin_for_interval(now_ns >= prev_ns ? now_ns - prev_ns
                                                                 : prev_ns - now_ns);
                    if (hist[slot] != '1)
                        hist[slot] = hist[slot] + 1'b1;
                    want.bin_index = slot[BIN_INDEX_W-1:0];
                    want.bin_count = hist[slot];
                    want.counted   = 1'b1;
                    last_sec       = i_arrival_sec;
                    last_nsec      = i_arrival_nsec;
                end
                expected_bins.push_back(want);
            end
        end
        o_pending    <= expected_bins.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

>>> verif/arrival_interval_histogram_tb.sv
// Testbench top for the arrival interval histogram: clock, reset, stimulus and verdict.
module arrival_interval_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aih_pkg::*;

    localparam int BINS         = 128;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_CYCLES  = 500;
    localparam logic [63:0] STAMP_TOP = 64'd4294967295999999999;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = CFG_MIN_NS;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_op = OP_RECORD;
    logic [TS_SEC_W-1:0]      i_arrival_sec = '0;
    logic [TS_NSEC_W-1:0]     i_arrival_nsec = '0;
    logic [BIN_INDEX_W-1:0]   i_read_bin = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [BIN_INDEX_W-1:0]   o_bin_index;
    logic [BIN_COUNT_W-1:0]   o_bin_count;
    logic                     o_counted;

    int          fail_count;
    int          pending;
    int          checked;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          arrivals_sent = 0;
    int          reads_sent = 0;
    int          settings_used = 1;
    logic        hold_wanted = 1'b0;
    logic        hold_served = 1'b0;
    logic [63:0] stamp_ns = '0;
    logic [CFG_W-1:0] range_lo = MIN_RESET_NS;
    logic [CFG_W-1:0] range_hi = MAX_RESET_NS;

    arrival_interval_histogram #(
        .BINS        (BINS),
        .COUNT_WIDTH (BIN_COUNT_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_arrival_sec  (i_arrival_sec),
        .i_arrival_nsec (i_arrival_nsec),
        .i_read_bin     (i_read_bin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bin_index    (o_bin_index),
        .o_bin_count    (o_bin_count),
        .o_counted      (o_counted)
    );

    arrival_interval_histogram_checker #(
        .BINS (BINS)
    ) i_hist_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_op           (i_op),
        .i_arrival_sec  (i_arrival_sec),
        .i_arrival_nsec (i_arrival_nsec),
        .i_read_bin     (i_read_bin),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_bin_index    (o_bin_index),
        .i_bin_count    (o_bin_count),
        .i_counted      (o_counted),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: stall patterns change every so often, with one long hold-off
    // that lets the block back up into its input.
    initial begin : receiver_stall
        int stall_pct;
        int mode_left;
        stall_pct = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_served) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
                i_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(input logic op, input logic [TS_SEC_W-1:0] sec,
                             input logic [TS_NSEC_W-1:0] nsec,
                             input logic [BIN_INDEX_W-1:0] rbin);
        int idle_len;
        if (burst_left == 0) begin
            case ($urandom_range(4))
                0:       idle_len = 0;
                1:       idle_len = $urandom_range(20, 60);
                default: idle_len = $urandom_range(1, 8);
            endcase
            if (idle_len > 0) begin
                i_valid <= 1'b0;
                repeat (idle_len) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_op           <= op;
        i_arrival_sec  <= sec;
        i_arrival_nsec <= nsec;
        i_read_bin     <= rbin;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_READ)
            reads_sent++;
        else
            arrivals_sent++;
    endtask

    task automatic send_raw_arrival(input logic [TS_SEC_W-1:0] sec,
                                    input logic [TS_NSEC_W-1:0] nsec);
        send_item(OP_RECORD, sec, nsec, BIN_INDEX_W'($urandom));
        stamp_ns = 64'(sec) * 64'(NS_PER_SEC) + 64'(nsec);
    endtask

    task automatic send_arrival_at(input logic [63:0] ts);
        send_raw_arrival(TS_SEC_W'(ts / 64'(NS_PER_SEC)), TS_NSEC_W'(ts % 64'(NS_PER_SEC)));
    endtask

    task automatic send_read(input logic [BIN_INDEX_W-1:0] rbin);
        send_item(OP_READ, $urandom, TS_NSEC_W'($urandom), rbin);
    endtask

    // Moves the timestamp by the given interval, mostly forward and sometimes back.
    task automatic send_interval(input logic [63:0] gap);
        if (stamp_ns >= gap && ($urandom_range(4) == 0 || STAMP_TOP - stamp_ns < gap))
            send_arrival_at(stamp_ns - gap);
        else
            send_arrival_at(stamp_ns + gap);
    endtask

    function automatic logic [63:0] pick_gap();
        logic [63:0] span;
        int unsigned k;
        if (range_hi > range_lo) begin
            span = 64'(range_hi) - 64'(range_lo);
            case ($urandom_range(9))
                0: return 64'($urandom_range(range_lo));
                1: return 64'(range_hi) + 64'($urandom_range(span[31:0]));
                2: begin
                    // Land on or just below the lower boundary of a random bin.
                    k = $urandom_range(1, BINS - 1);
                    return 64'(range_lo) + (span * k + BINS - 1) / BINS
                           - 64'($urandom_range(1));
                end
                3: return 64'(range_lo) + 64'($urandom_range(1));
                default: return 64'(range_lo) + ((span * 64'($urandom)) >> 32);
            endcase
        end
        case ($urandom_range(3))
            0:       return 64'd0;
            1:       return 64'(range_lo);
            2:       return 64'(range_lo) + 64'd1;
            default: return 64'($urandom) * 64'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic run_mix(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_read(BIN_INDEX_W'($urandom));
            else if (pick < 25)
                send_raw_arrival($urandom, TS_NSEC_W'($urandom));
            else
                send_interval(pick_gap());
        end
    endtask

    task automatic drain_results();
        i_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_range(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_NS;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_NS;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        range_lo = lo;
        range_hi = hi;
        settings_used++;
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset range of 0.5 ms to 7 ms.
        send_read(7'd0);
        send_read(7'd127);
        send_arrival_at(64'd0);
        send_raw_arrival('1, '1);
        send_arrival_at(64'd0);
        send_interval(64'(MIN_RESET_NS));
        send_interval(64'(MIN_RESET_NS) + 64'd1);
        send_interval(64'd550781);
        send_interval(64'd550782);
        send_interval(64'd6949218);
        send_interval(64'd6949219);
        send_interval(64'(MAX_RESET_NS) - 64'd1);
        send_interval(64'(MAX_RESET_NS));
        send_interval(64'd1000);
        send_interval(64'd0);
        send_raw_arrival(32'd3, 30'h3FFF_FFFF);
        send_read(7'd0);
        send_read(7'd1);
        send_read(7'd126);
        send_read(7'd127);

        hold_wanted = 1'b1;
        run_mix(260);
        set_range(32'd0, 32'hFFFF_FFFF);
        run_mix(200);
        // One nanosecond per bin.
        set_range(32'd1000, 32'd1128);
        run_mix(250);
        set_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_mix(80);
        set_range(32'd0, 32'd0);
        run_mix(80);
        set_range(MAX_RESET_NS, MIN_RESET_NS);
        run_mix(100);
        set_range(32'd12345, 32'd12645);
        run_mix(200);
        set_range(32'hFFF0_0000, 32'hFFFF_FFFF);
        run_mix(150);
        set_range(MIN_RESET_NS, MAX_RESET_NS);
        run_mix(230);

        drain_results();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d arrivals and %0d bin reads across %0d range settings; %0d results compared.",
                 arrivals_sent, reads_sent, settings_used, checked);
        $display("Included empty, reversed and full-width ranges, bin boundaries and a long result hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/aih_pkg.sv
hw/rtl/aih_interval.sv
hw/rtl/aih_bin_div.sv
hw/rtl/aih_hist.sv
hw/rtl/arrival_interval_histogram.sv
verif/arrival_interval_histogram_checker.sv
verif/arrival_interval_histogram_tb.sv
